FILE: sv/fgc_pkg.sv
// ============================================================================
// fgc_pkg
// Shared codes, reset values and flag types for the footswitch gesture
// controller.
// ============================================================================
`default_nettype none

package fgc_pkg;

    // item kind on the input tuser
    localparam logic [1:0] FUNC_PRESS     = 2'd0;
    localparam logic [1:0] FUNC_RELEASE   = 2'd1;
    localparam logic [1:0] FUNC_POLL      = 2'd2;
    localparam logic [1:0] FUNC_TELEMETRY = 2'd3;

    // action kind on the output tuser
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_TUNER = 2'd2;

    // looper command codes
    localparam logic [2:0] CMD_REC     = 3'd0;
    localparam logic [2:0] CMD_AUDIBLE = 3'd1;
    localparam logic [2:0] CMD_UNDO    = 3'd2;
    localparam logic [2:0] CMD_CLEAR   = 3'd3;
    localparam logic [2:0] CMD_PAUSE   = 3'd4;
    localparam logic [2:0] CMD_RESUME  = 3'd5;

    // session states that matter
    localparam logic [2:0] SESS_INACTIVE  = 3'd0;
    localparam logic [2:0] SESS_PAUSED    = 3'd2;
    localparam logic [2:0] SESS_RUNNING   = 3'd3;
    localparam logic [2:0] SESS_REC_MASTR = 3'd4;

    // switch indexes
    localparam logic [1:0] SW_UNDO  = 2'd0;
    localparam logic [1:0] SW_TRACK = 2'd1;
    localparam logic [1:0] SW_REC   = 2'd2;
    localparam logic [1:0] SW_AUD   = 2'd3;

    localparam int SWITCH_COUNT = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_CHORD_WINDOW = 2'd0;
    localparam logic [1:0] CFG_TUNER_HOLD   = 2'd1;
    localparam logic [1:0] CFG_CLEAR_HOLD   = 2'd2;

    localparam logic [15:0] CHORD_WINDOW_RST = 16'd100;
    localparam logic [15:0] TUNER_HOLD_RST   = 16'd1000;
    localparam logic [15:0] CLEAR_HOLD_RST   = 16'd1000;
    localparam logic [31:0] SEQ_RST          = 32'd1;

    typedef struct packed {
        logic resume;
        logic ready;
        logic pending;
        logic active;
    } tuner_flags_t;

    typedef struct packed {
        logic clear;
        logic trig;
        logic active;
    } chord_flags_t;

endpackage

`default_nettype wire

FILE: sv/footswitch_gesture_controller.sv
// ============================================================================
// footswitch_gesture_controller
// Turns footswitch presses/releases, time polls and telemetry words into
// looper actions: at most one result word per input word.
// ============================================================================
`default_nettype none

// One input word is taken per clock. It lands in an input register, the
// gesture and tuner logic works on it combinationally, and the result
// (if any) goes to an output register. Throughput is one word per cycle;
// only a stalled output (m_tready low with a result held) holds the
// input side back. Words that cause no action produce no output word.
// Switch 2 sends record/overdub, switch 3 toggles audible, a tap on switch 0
// sends undo, a tap on switch 1 steps the selected track and holding it
// sends a track clear. Pressing 0 and 1 inside the chord window and holding
// both requests the tuner, possibly after a pause that telemetry confirms.
// Configuration writes take effect at once and must be issued while idle.
module footswitch_gesture_controller #(
    parameter int TRACK_COUNT = 4
) (
    input  wire         aclk,
    input  wire         aresetn,
    // config write port
    input  wire         cfg_wr_en,
    input  wire  [1:0]  cfg_addr,
    input  wire  [15:0] cfg_wr_data,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] switch_index, [33:2] time_now, [36:34] session_state,
    // [40:37] track_capture_mask, [72:41] applied_sequence, [79:73] zero
    input  wire  [79:0] s_tdata,
    // [1:0] func
    input  wire  [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // [2:0] command_code, [4:3] command_track, [36:5] command_sequence,
    // [39:37] zero
    output logic [39:0] m_tdata,
    // [1:0] action_kind
    output logic [1:0]  m_tuser
);

    localparam int SEL_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

    // ---------------- configuration ----------------
    logic [15:0] chord_win_reg, tuner_hold_reg, clear_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chord_win_reg  <= fgc_pkg::CHORD_WINDOW_RST;
            tuner_hold_reg <= fgc_pkg::TUNER_HOLD_RST;
            clear_hold_reg <= fgc_pkg::CLEAR_HOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                fgc_pkg::CFG_CHORD_WINDOW: chord_win_reg  <= cfg_wr_data;
                fgc_pkg::CFG_TUNER_HOLD:   tuner_hold_reg <= cfg_wr_data;
                fgc_pkg::CFG_CLEAR_HOLD:   clear_hold_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic [1:0]  func_reg;
    logic [1:0]  idx_reg;
    logic [31:0] now_reg;
    logic [2:0]  st_reg;
    logic [3:0]  mask_reg;
    logic [31:0] applied_reg;
    logic        advance;

    // the held word moves on when the output register can take its result
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg    <= s_tuser;
            idx_reg     <= s_tdata[1:0];
            now_reg     <= s_tdata[33:2];
            st_reg      <= s_tdata[36:34];
            mask_reg    <= s_tdata[40:37];
            applied_reg <= s_tdata[72:41];
        end
    end

    // ---------------- controller state ----------------
    logic [31:0]           seq_reg, seq_next;
    logic [SEL_W-1:0]      sel_reg, sel_next;
    logic                  locked_reg, locked_next;
    logic [2:0]            last_st_reg, last_st_next;
    logic [3:0]            last_mask_reg, last_mask_next;
    fgc_pkg::tuner_flags_t tuner_reg, tuner_next;
    logic [31:0]           pause_seq_reg, pause_seq_next;
    logic [3:0]            down_reg, down_next;
    logic [1:0]            tap_reg, tap_next;
    logic [31:0]           pt0_reg, pt0_next;
    logic [31:0]           pt1_reg, pt1_next;
    fgc_pkg::chord_flags_t chord_reg, chord_next;
    logic [31:0]           chord_t0_reg, chord_t0_next;

    // result of the word in the input register
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [2:0]  res_code;
    logic [1:0]  res_track;
    logic [31:0] res_seq;

    // selected track as seen on the 2-bit command_track field
    logic [31:0] sel_wide;
    logic [1:0]  sel_track;
    assign sel_wide  = 32'(sel_reg);
    assign sel_track = sel_wide[1:0];

    // wrapped elapsed times
    logic [31:0] dt_other, dt_chord, dt_hold1;
    logic        other_sel;
    assign other_sel = ~idx_reg[0];
    assign dt_other  = now_reg - (other_sel ? pt1_reg : pt0_reg);
    assign dt_chord  = now_reg - chord_t0_reg;
    assign dt_hold1  = now_reg - pt1_reg;

    logic in_window, chord_held, clear_held, capture;
    assign in_window  = dt_other <= {16'd0, chord_win_reg};
    assign chord_held = dt_chord >= {16'd0, tuner_hold_reg};
    assign clear_held = dt_hold1 >= {16'd0, clear_hold_reg};
    assign capture    = (last_st_reg == fgc_pkg::SESS_REC_MASTR) || (last_mask_reg != 4'd0);

    always_comb begin
        seq_next       = seq_reg;
        sel_next       = sel_reg;
        locked_next    = locked_reg;
        last_st_next   = last_st_reg;
        last_mask_next = last_mask_reg;
        tuner_next     = tuner_reg;
        pause_seq_next = pause_seq_reg;
        down_next      = down_reg;
        tap_next       = tap_reg;
        pt0_next       = pt0_reg;
        pt1_next       = pt1_reg;
        chord_next     = chord_reg;
        chord_t0_next  = chord_t0_reg;
        res_valid      = 1'b0;
        res_kind       = fgc_pkg::KIND_NONE;
        res_code       = fgc_pkg::CMD_REC;
        res_track      = 2'd0;
        res_seq        = 32'd0;

        case (func_reg)
            fgc_pkg::FUNC_PRESS, fgc_pkg::FUNC_RELEASE: begin
                if (tuner_reg.active) begin
                    // any press leaves the tuner; releases are ignored there
                    if (func_reg == fgc_pkg::FUNC_PRESS) begin
                        tuner_next.active = 1'b0;
                        down_next         = 4'd0;
                        tap_next          = 2'd0;
                        chord_next        = '0;
                        if (tuner_reg.resume) begin
                            tuner_next.resume = 1'b0;
                            res_valid = 1'b1;
                            res_kind  = fgc_pkg::KIND_CMD;
                            res_code  = fgc_pkg::CMD_RESUME;
                            res_seq   = seq_reg;
                            seq_next  = seq_reg + 32'd1;
                        end
                    end
                end else if (locked_reg) begin
                    if (func_reg == fgc_pkg::FUNC_PRESS) begin
                        if (!down_reg[idx_reg]) begin
                            down_next[idx_reg] = 1'b1;
                            if (idx_reg == fgc_pkg::SW_REC || idx_reg == fgc_pkg::SW_AUD) begin
                                res_valid = 1'b1;
                                res_kind  = fgc_pkg::KIND_CMD;
                                res_code  = (idx_reg == fgc_pkg::SW_REC) ?
                                            fgc_pkg::CMD_REC : fgc_pkg::CMD_AUDIBLE;
                                res_track = sel_track;
                                res_seq   = seq_reg;
                                seq_next  = seq_reg + 32'd1;
                            end else begin
                                if (idx_reg[0]) pt1_next = now_reg;
                                else            pt0_next = now_reg;
                                tap_next[idx_reg[0]] = 1'b1;
                                // second press of the pair close enough: chord
                                if (down_reg[{1'b0, other_sel}] && in_window) begin
                                    chord_next.active = 1'b1;
                                    chord_next.trig   = 1'b0;
                                    chord_t0_next     = now_reg;
                                    tap_next          = 2'd0;
                                end
                            end
                        end
                    end else if (down_reg[idx_reg]) begin
                        down_next[idx_reg] = 1'b0;
                        if (idx_reg == fgc_pkg::SW_UNDO || idx_reg == fgc_pkg::SW_TRACK) begin
                            if (chord_reg.active) begin
                                if (!down_next[0] && !down_next[1]) begin
                                    chord_next.active = 1'b0;
                                    chord_next.trig   = 1'b0;
                                end
                                tap_next[idx_reg[0]] = 1'b0;
                            end else if (idx_reg == fgc_pkg::SW_TRACK && chord_reg.clear) begin
                                // release after a hold-clear is not a tap
                                chord_next.clear = 1'b0;
                                tap_next[1]      = 1'b0;
                            end else if (tap_reg[idx_reg[0]]) begin
                                tap_next[idx_reg[0]] = 1'b0;
                                if (idx_reg == fgc_pkg::SW_UNDO) begin
                                    res_valid = 1'b1;
                                    res_kind  = fgc_pkg::KIND_CMD;
                                    res_code  = fgc_pkg::CMD_UNDO;
                                    res_track = sel_track;
                                    res_seq   = seq_reg;
                                    seq_next  = seq_reg + 32'd1;
                                end else if (sel_reg == SEL_W'(TRACK_COUNT - 1)) begin
                                    sel_next = '0;
                                end else begin
                                    sel_next = sel_reg + SEL_W'(1);
                                end
                            end
                        end
                    end
                end
            end
            fgc_pkg::FUNC_POLL: begin
                if (tuner_reg.ready) begin
                    tuner_next.ready  = 1'b0;
                    tuner_next.active = 1'b1;
                    res_valid = 1'b1;
                    res_kind  = fgc_pkg::KIND_TUNER;
                end else if (chord_reg.active && !chord_reg.trig && down_reg[0] && down_reg[1]
                             && chord_held) begin
                    chord_next.trig = 1'b1;
                    if (!tuner_reg.active && !tuner_reg.pending && !tuner_reg.ready) begin
                        if (capture || last_st_reg == fgc_pkg::SESS_RUNNING) begin
                            // pause first; resume owed only if nothing was capturing
                            tuner_next.resume  = !capture;
                            tuner_next.pending = 1'b1;
                            pause_seq_next     = seq_reg;
                            res_valid = 1'b1;
                            res_kind  = fgc_pkg::KIND_CMD;
                            res_code  = fgc_pkg::CMD_PAUSE;
                            res_seq   = seq_reg;
                            seq_next  = seq_reg + 32'd1;
                        end else begin
                            tuner_next.resume = 1'b0;
                            tuner_next.active = 1'b1;
                            res_valid = 1'b1;
                            res_kind  = fgc_pkg::KIND_TUNER;
                        end
                    end
                end else if (down_reg[1] && tap_reg[1] && !chord_reg.clear && clear_held) begin
                    chord_next.clear = 1'b1;
                    tap_next[1]      = 1'b0;
                    res_valid = 1'b1;
                    res_kind  = fgc_pkg::KIND_CMD;
                    res_code  = fgc_pkg::CMD_CLEAR;
                    res_track = sel_track;
                    res_seq   = seq_reg;
                    seq_next  = seq_reg + 32'd1;
                end
            end
            fgc_pkg::FUNC_TELEMETRY: begin
                last_st_next   = st_reg;
                last_mask_next = mask_reg;
                locked_next    = st_reg != fgc_pkg::SESS_INACTIVE;
                // pause confirmed once the engine has applied it
                if (tuner_reg.pending && applied_reg >= pause_seq_reg) begin
                    tuner_next.pending = 1'b0;
                    if (st_reg == fgc_pkg::SESS_PAUSED) tuner_next.ready  = 1'b1;
                    else                                tuner_next.resume = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= fgc_pkg::SEQ_RST;
            sel_reg       <= '0;
            locked_reg    <= 1'b0;
            last_st_reg   <= fgc_pkg::SESS_INACTIVE;
            last_mask_reg <= 4'd0;
            tuner_reg     <= '0;
            pause_seq_reg <= 32'd0;
            down_reg      <= 4'd0;
            tap_reg       <= 2'd0;
            pt0_reg       <= 32'd0;
            pt1_reg       <= 32'd0;
            chord_reg     <= '0;
            chord_t0_reg  <= 32'd0;
        end else if (advance) begin
            seq_reg       <= seq_next;
            sel_reg       <= sel_next;
            locked_reg    <= locked_next;
            last_st_reg   <= last_st_next;
            last_mask_reg <= last_mask_next;
            tuner_reg     <= tuner_next;
            pause_seq_reg <= pause_seq_next;
            down_reg      <= down_next;
            tap_reg       <= tap_next;
            pt0_reg       <= pt0_next;
            pt1_reg       <= pt1_next;
            chord_reg     <= chord_next;
            chord_t0_reg  <= chord_t0_next;
        end
    end

    // ---------------- output register ----------------
    logic m_valid_reg;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_tuser <= res_kind;
            m_tdata <= {3'd0, res_seq, res_track, res_code};
        end
    end

    // ---------------- assertions ----------------
    // tuner is idle, waiting on a pause, ready, or on; never two at once
    a_tuner_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({tuner_reg.active, tuner_reg.pending, tuner_reg.ready}))
        else $error("tuner flags overlap");

    // a shown result always carries a real action
    a_kind_real: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == fgc_pkg::KIND_CMD || m_tuser == fgc_pkg::KIND_TUNER))
        else $error("result without action");

    // enter-tuner results carry all-zero command fields
    a_tuner_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == fgc_pkg::KIND_TUNER) |-> (m_tdata == 40'd0))
        else $error("tuner result with command fields");

    // each issued command consumes exactly one sequence number
    a_seq_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid && res_kind == fgc_pkg::KIND_CMD)
        |=> (seq_reg == $past(seq_reg) + 32'd1))
        else $error("sequence did not advance");

endmodule

`default_nettype wire

FILE: tb/tb_footswitch_gesture_controller.sv
// ----------------------------------------------------------------------------
// tb_footswitch_gesture_controller
// Self-checking bench for the footswitch gesture controller. Input words come
// from a queue that the stimulus process fills. A clocked driver plays them out
// and a clocked monitor takes the action words. A word-level mirror of the
// gesture and tuner state predicts each action, and the actions are compared
// field by field, in order. The run covers four configuration phases: the
// reset values, all zero, all ones (with no idling), and random values.
// ----------------------------------------------------------------------------
module tb_footswitch_gesture_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 60000;
    localparam int GAP_PCT     = 16;       // idle cycles per hundred, each side

    // one input word, unpacked view of s_tdata/s_tuser
    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  sw;
        logic [31:0] t_ms;
        logic [2:0]  sess;
        logic [3:0]  capture;
        logic [31:0] applied;
    } footswitch_word_t;

    // one result word, unpacked view of m_tuser/m_tdata
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  code;
        logic [1:0]  track;
        logic [31:0] seq;
    } looper_action_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = fgc_pkg::CFG_CHORD_WINDOW;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata     = 80'd0;
    logic [1:0]  s_tuser     = fgc_pkg::FUNC_POLL;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    always #CLK_HALF aclk = ~aclk;

    footswitch_gesture_controller DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    footswitch_word_t pending_words[$];     // filled by stimulus, drained by driver
    looper_action_t   expected_actions[$];  // predicted, oldest first
    footswitch_word_t word_on_bus;
    int               words_queued = 0;
    int               mismatches   = 0;
    int               cycle_count  = 0;
    bit               no_gaps      = 1'b0;  // both sides run flat out when set
    logic [31:0]      gen_ms;               // time stamp of the next generated word

    // ------------------------------------------------------------------------
    // Mirror of the controller: configuration, gesture and tuner state
    // ------------------------------------------------------------------------
    logic [15:0]           win_ms, tuner_ms, clear_ms;
    logic [31:0]           seq_next;
    logic [1:0]            sel_track;
    logic                  locked;
    logic [2:0]            sess_seen;
    logic [3:0]            capture_seen;
    fgc_pkg::tuner_flags_t tuner;
    logic [31:0]           pause_seq;
    logic [3:0]            sw_down;
    logic [1:0]            tap_armed;
    logic [31:0]           pressed_at [2];
    fgc_pkg::chord_flags_t chord;
    logic [31:0]           chord_t0;

    // command word; takes the next sequence number
    function automatic void make_cmd(input logic [2:0] code, input logic [1:0] track,
                                     output looper_action_t act);
        act.kind  = fgc_pkg::KIND_CMD;
        act.code  = code;
        act.track = track;
        act.seq   = seq_next;
        seq_next  = seq_next + 32'd1;
    endfunction

    // chord held long enough: pause first if the looper is moving
    function automatic bit request_tuner(output looper_action_t act);
        bit capturing;
        act = '0;
        if (tuner.active || tuner.pending || tuner.ready) return 1'b0;
        capturing = (sess_seen == fgc_pkg::SESS_REC_MASTR) || (capture_seen != 4'd0);
        if (capturing || sess_seen == fgc_pkg::SESS_RUNNING) begin
            tuner.resume  = !capturing;     // no resume owed while capturing
            pause_seq     = seq_next;
            tuner.pending = 1'b1;
            make_cmd(fgc_pkg::CMD_PAUSE, 2'd0, act);
            return 1'b1;
        end
        tuner.resume = 1'b0;
        tuner.active = 1'b1;
        act.kind     = fgc_pkg::KIND_TUNER;
        return 1'b1;
    endfunction

    function automatic bit switch_event(input bit press, input logic [1:0] sw,
                                        input logic [31:0] t_ms,
                                        output looper_action_t act);
        logic        other;
        logic [31:0] gap;
        act = '0;
        // in the tuner: releases are dropped, any press leaves it
        if (tuner.active) begin
            if (!press) return 1'b0;
            tuner.active = 1'b0;
            sw_down      = '0;
            tap_armed    = '0;
            chord        = '0;
            if (tuner.resume) begin
                tuner.resume = 1'b0;
                make_cmd(fgc_pkg::CMD_RESUME, 2'd0, act);
                return 1'b1;
            end
            return 1'b0;
        end
        if (!locked) return 1'b0;
        if (press) begin
            if (sw_down[sw]) return 1'b0;
            sw_down[sw] = 1'b1;
            if (sw == fgc_pkg::SW_REC) begin
                make_cmd(fgc_pkg::CMD_REC, sel_track, act);
                return 1'b1;
            end
            if (sw == fgc_pkg::SW_AUD) begin
                make_cmd(fgc_pkg::CMD_AUDIBLE, sel_track, act);
                return 1'b1;
            end
            other              = !sw[0];
            pressed_at[sw[0]]  = t_ms;
            tap_armed[sw[0]]   = 1'b1;
            gap                = t_ms - pressed_at[other];
            if (sw_down[other] && gap <= {16'd0, win_ms}) begin
                chord.active = 1'b1;
                chord.trig   = 1'b0;
                chord_t0     = t_ms;
                tap_armed    = '0;
            end
            return 1'b0;
        end
        if (!sw_down[sw]) return 1'b0;
        sw_down[sw] = 1'b0;
        if (sw[1]) return 1'b0;
        if (chord.active) begin
            if (!sw_down[0] && !sw_down[1]) begin
                chord.active = 1'b0;
                chord.trig   = 1'b0;
            end
            tap_armed[sw[0]] = 1'b0;
            return 1'b0;
        end
        // release after a hold-to-clear is not a tap
        if (sw == fgc_pkg::SW_TRACK && chord.clear) begin
            chord.clear  = 1'b0;
            tap_armed[1] = 1'b0;
            return 1'b0;
        end
        if (!tap_armed[sw[0]]) return 1'b0;
        tap_armed[sw[0]] = 1'b0;
        if (sw == fgc_pkg::SW_UNDO) begin
            make_cmd(fgc_pkg::CMD_UNDO, sel_track, act);
            return 1'b1;
        end
        sel_track = sel_track + 2'd1;       // four tracks, wraps in two bits
        return 1'b0;
    endfunction

    function automatic bit poll_event(input logic [31:0] t_ms, output looper_action_t act);
        logic [31:0] held_chord, held_track;
        act        = '0;
        held_chord = t_ms - chord_t0;
        held_track = t_ms - pressed_at[1];
        if (tuner.ready) begin
            tuner.ready  = 1'b0;
            tuner.active = 1'b1;
            act.kind     = fgc_pkg::KIND_TUNER;
            return 1'b1;
        end
        if (chord.active && !chord.trig && sw_down[0] && sw_down[1]
            && held_chord >= {16'd0, tuner_ms}) begin
            chord.trig = 1'b1;
            return request_tuner(act);
        end
        if (sw_down[1] && tap_armed[1] && !chord.clear && held_track >= {16'd0, clear_ms}) begin
            chord.clear  = 1'b1;
            tap_armed[1] = 1'b0;
            make_cmd(fgc_pkg::CMD_CLEAR, sel_track, act);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit predict_action(input footswitch_word_t w,
                                          output looper_action_t act);
        act = '0;
        case (w.func)
            fgc_pkg::FUNC_PRESS:   return switch_event(1'b1, w.sw, w.t_ms, act);
            fgc_pkg::FUNC_RELEASE: return switch_event(1'b0, w.sw, w.t_ms, act);
            fgc_pkg::FUNC_POLL:    return poll_event(w.t_ms, act);
            default: begin
                // telemetry: lock follows session state, may confirm a pause
                sess_seen    = w.sess;
                capture_seen = w.capture;
                locked       = (w.sess != fgc_pkg::SESS_INACTIVE);
                if (tuner.pending && w.applied >= pause_seq) begin
                    tuner.pending = 1'b0;
                    if (w.sess == fgc_pkg::SESS_PAUSED) tuner.ready = 1'b1;
                    else tuner.resume = 1'b0;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: accepts at the rising edge, presents the next word at the
    // falling edge. Gaps only fall between words, never inside a handshake.
    // ------------------------------------------------------------------------
    always begin : word_driver
        looper_action_t predicted;
        bit             word_taken;
        @(posedge aclk);
        word_taken = aresetn && s_tvalid && s_tready;
        if (word_taken && predict_action(word_on_bus, predicted))
            expected_actions.push_back(predicted);
        @(negedge aclk);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (pending_words.size() != 0
                && (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
                word_on_bus = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, word_on_bus.applied, word_on_bus.capture,
                             word_on_bus.sess, word_on_bus.t_ms, word_on_bus.sw};
                s_tuser  <= word_on_bus.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples at the rising edge, compares at the following falling
    // edge so every prediction from that rising edge is already queued.
    // ------------------------------------------------------------------------
    always begin : action_monitor
        looper_action_t seen, want;
        bit             seen_valid;
        @(posedge aclk);
        seen_valid = aresetn && m_tvalid && m_tready;
        seen       = {m_tuser, m_tdata[2:0], m_tdata[4:3], m_tdata[36:5]};
        @(negedge aclk);
        m_tready <= aresetn && (no_gaps || $urandom_range(0, 99) >= GAP_PCT);
        if (seen_valid) begin
            if (expected_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected action kind %0d code %0d track %0d seq %0d",
                             $realtime, seen.kind, seen.code, seen.track, seen.seq);
            end else begin
                want = expected_actions.pop_front();
                if (seen.kind !== want.kind || seen.code !== want.code
                    || seen.track !== want.track || seen.seq !== want.seq) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: action mismatch", $realtime);
                        $display("  expected kind %0d code %0d track %0d seq %0d",
                                 want.kind, want.code, want.track, want.seq);
                        $display("  got      kind %0d code %0d track %0d seq %0d",
                                 seen.kind, seen.code, seen.track, seen.seq);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // every field but func random, time stamp from gen_ms
    function automatic footswitch_word_t fresh_word(input logic [1:0] func);
        footswitch_word_t w;
        w.func    = func;
        w.sw      = 2'($urandom_range(0, 3));
        w.t_ms    = gen_ms;
        w.sess    = 3'($urandom_range(0, 7));
        w.capture = 4'($urandom_range(0, 15));
        w.applied = $urandom();
        return w;
    endfunction

    task automatic add_word(input logic [1:0] func, input logic [1:0] sw,
                            input logic [31:0] dt);
        footswitch_word_t w;
        gen_ms = gen_ms + dt;
        w      = fresh_word(func);
        w.sw   = sw;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic add_telemetry(input logic [2:0] sess, input logic [3:0] capture,
                                 input logic [31:0] applied, input logic [31:0] dt);
        footswitch_word_t w;
        gen_ms    = gen_ms + dt;
        w         = fresh_word(fgc_pkg::FUNC_TELEMETRY);
        w.sess    = sess;
        w.capture = capture;
        w.applied = applied;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // delay around a threshold: just under, on, just over, anywhere up to it, well over
    function automatic logic [31:0] near(input logic [15:0] thr);
        case ($urandom_range(0, 4))
            0:       return (thr == 16'd0) ? 32'd0 : thr - 32'd1;
            1:       return {16'd0, thr};
            2:       return thr + 32'd1;
            3:       return $urandom_range(0, thr);
            default: return thr + $urandom_range(0, 3000);
        endcase
    endfunction

    function automatic logic [2:0] pick_session();
        case ($urandom_range(0, 9))
            0:       return fgc_pkg::SESS_INACTIVE;
            1, 2:    return fgc_pkg::SESS_PAUSED;
            3, 4, 5: return fgc_pkg::SESS_RUNNING;
            6:       return fgc_pkg::SESS_REC_MASTR;
            default: return 3'($urandom_range(1, 7));
        endcase
    endfunction

    function automatic logic [3:0] pick_capture();
        return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    endfunction

    // pause sequences stay small, so these land on both sides of the compare
    function automatic logic [31:0] pick_applied();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return $urandom_range(0, 2000);
            2:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // random gestures, mostly well formed, some stray and noise words
    task automatic run_gestures(input int count);
        int         stop_at;
        logic [1:0] first_sw, second_sw;
        stop_at = words_queued + count;
        while (words_queued < stop_at) begin
            first_sw  = 2'($urandom_range(0, 1));
            second_sw = {1'b0, ~first_sw[0]};
            case ($urandom_range(0, 11))
                0, 1: begin     // tap, sometimes a poll in the middle
                    add_word(fgc_pkg::FUNC_PRESS, first_sw, $urandom_range(1, 50));
                    if ($urandom_range(0, 1))
                        add_word(fgc_pkg::FUNC_POLL, 2'($urandom_range(0, 3)), near(clear_ms));
                    add_word(fgc_pkg::FUNC_RELEASE, first_sw, $urandom_range(0, 50));
                end
                2: begin        // hold on the track switch
                    add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_TRACK, $urandom_range(1, 50));
                    add_word(fgc_pkg::FUNC_POLL, 2'($urandom_range(0, 3)), near(clear_ms));
                    add_word(fgc_pkg::FUNC_POLL, 2'($urandom_range(0, 3)),
                             $urandom_range(0, 20));
                    add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_TRACK, $urandom_range(0, 50));
                end
                3, 4, 5: begin  // chord and tuner request
                    add_telemetry(pick_session(), pick_capture(), pick_applied(),
                                  $urandom_range(0, 30));
                    add_word(fgc_pkg::FUNC_PRESS, first_sw, $urandom_range(1, 50));
                    add_word(fgc_pkg::FUNC_PRESS, second_sw, near(win_ms));
                    add_word(fgc_pkg::FUNC_POLL, 2'($urandom_range(0, 3)), near(tuner_ms));
                    if ($urandom_range(0, 2) != 0) begin
                        add_telemetry($urandom_range(0, 2) ? fgc_pkg::SESS_PAUSED
                                                           : pick_session(),
                                      pick_capture(), pick_applied(), $urandom_range(0, 30));
                        add_word(fgc_pkg::FUNC_POLL, 2'($urandom_range(0, 3)),
                                 $urandom_range(0, 30));
                    end
                    add_word(fgc_pkg::FUNC_RELEASE,
                             $urandom_range(0, 1) ? first_sw : second_sw,
                             $urandom_range(0, 50));
                    add_word(fgc_pkg::FUNC_RELEASE,
                             $urandom_range(0, 1) ? first_sw : second_sw,
                             $urandom_range(0, 50));
                    if ($urandom_range(0, 1))
                        add_word(fgc_pkg::FUNC_PRESS, 2'($urandom_range(0, 3)),
                                 $urandom_range(0, 50));
                end
                6: begin        // record or audible
                    first_sw = $urandom_range(0, 1) ? fgc_pkg::SW_REC : fgc_pkg::SW_AUD;
                    add_word(fgc_pkg::FUNC_PRESS, first_sw, $urandom_range(0, 50));
                    add_word(fgc_pkg::FUNC_RELEASE, first_sw, $urandom_range(0, 50));
                end
                7, 8: add_telemetry(pick_session(), pick_capture(), pick_applied(),
                                    $urandom_range(0, 100));
                9:  add_word(fgc_pkg::FUNC_PRESS, 2'($urandom_range(0, 3)),
                             $urandom_range(0, 100));
                10: add_word($urandom_range(0, 1) ? fgc_pkg::FUNC_RELEASE : fgc_pkg::FUNC_PRESS,
                             2'($urandom_range(0, 3)), $urandom_range(0, 100));
                default: add_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                  $urandom());
            endcase
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            fgc_pkg::CFG_CHORD_WINDOW: win_ms   = val;
            fgc_pkg::CFG_TUNER_HOLD:   tuner_ms = val;
            default:                   clear_ms = val;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] win, input logic [15:0] tun,
                             input logic [15:0] clr);
        write_reg(fgc_pkg::CFG_CHORD_WINDOW, win);
        write_reg(fgc_pkg::CFG_TUNER_HOLD, tun);
        write_reg(fgc_pkg::CFG_CLEAR_HOLD, clr);
        @(posedge aclk);    // fill the queue away from the driver's edge
    endtask

    // idle: nothing queued, nothing on the bus, nothing outstanding, then settle
    task automatic wait_quiet(input int settle);
        @(posedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_actions.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        win_ms       = fgc_pkg::CHORD_WINDOW_RST;
        tuner_ms     = fgc_pkg::TUNER_HOLD_RST;
        clear_ms     = fgc_pkg::CLEAR_HOLD_RST;
        seq_next     = fgc_pkg::SEQ_RST;
        sel_track    = 2'd0;
        locked       = 1'b0;
        sess_seen    = fgc_pkg::SESS_INACTIVE;
        capture_seen = 4'd0;
        tuner        = '0;
        pause_seq    = 32'd0;
        sw_down      = '0;
        tap_armed    = '0;
        pressed_at   = '{32'd0, 32'd0};
        chord        = '0;
        chord_t0     = 32'd0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk, reset configuration; starts at the top of the time
        // range so the first words carry all-ones and zero time stamps
        gen_ms = 32'hFFFF_FFFE;
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_REC, 32'd1);      // unlocked: ignored
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_REC, 32'd1);
        add_telemetry(3'd7, 4'd0, 32'd0, 32'd1);                    // state 7 still locks
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_REC, 32'd1);      // record
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_REC, 32'd1);      // already down
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_REC, 32'd1);
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_REC, 32'd1);    // already up
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_AUD, 32'd1);      // audible
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_AUD, 32'd1);
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_UNDO, 32'd5);
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_UNDO, 32'd5);   // undo tap
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_TRACK, 32'd5);
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_TRACK, 32'd5);  // step to track 1
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_TRACK, 32'd5);
        // clear track 1
        add_word(fgc_pkg::FUNC_POLL, fgc_pkg::SW_UNDO, 32'(fgc_pkg::CLEAR_HOLD_RST));
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_TRACK, 32'd5);  // swallowed after clear
        add_telemetry(fgc_pkg::SESS_RUNNING, 4'd0, 32'd0, 32'd1);
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_UNDO, 32'd5);
        // chord at window edge
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_TRACK, 32'(fgc_pkg::CHORD_WINDOW_RST));
        add_word(fgc_pkg::FUNC_POLL, fgc_pkg::SW_UNDO,
                 32'(fgc_pkg::TUNER_HOLD_RST) - 32'd1);
        add_word(fgc_pkg::FUNC_POLL, fgc_pkg::SW_UNDO, 32'd1);      // pause, resume owed
        add_telemetry(fgc_pkg::SESS_PAUSED, 4'd0, 32'hFFFF_FFFF, 32'd1);
        add_word(fgc_pkg::FUNC_POLL, fgc_pkg::SW_AUD, 32'd1);       // enter tuner
        add_word(fgc_pkg::FUNC_RELEASE, fgc_pkg::SW_UNDO, 32'd1);   // dropped in tuner
        add_word(fgc_pkg::FUNC_PRESS, fgc_pkg::SW_AUD, 32'd1);      // leave tuner, resume
        add_telemetry(fgc_pkg::SESS_INACTIVE, 4'hF, 32'd0, 32'd1);
        run_gestures(120);
        wait_quiet(4);

        // all thresholds zero
        write_all(16'd0, 16'd0, 16'd0);
        add_telemetry(fgc_pkg::SESS_RUNNING, 4'd0, 32'd0, 32'd1);
        run_gestures(100);
        wait_quiet(4);

        // all thresholds at max, one long stretch without idling
        no_gaps = 1'b1;
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
        gen_ms = $urandom();
        add_telemetry(fgc_pkg::SESS_RUNNING, 4'd0, 32'd0, 32'd1);
        run_gestures(100);
        wait_quiet(4);
        no_gaps = 1'b0;

        // random mid-range thresholds
        write_all(16'($urandom_range(1, 400)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 3000)));
        add_telemetry(fgc_pkg::SESS_PAUSED, 4'd0, 32'd0, 32'd1);
        run_gestures(130);
        wait_quiet(8);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
